// ===== hdl/kshash_pkg.sv =====
// kshash_pkg: constants, types and helpers for the keyed string hash
// used by the front end, the entry queue and the finalizer back end
package kshash_pkg;

    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
    localparam logic [63:0] GOLDEN    = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_M1    = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_M2    = 64'h94D049BB133111EB;

    localparam int SHIFT_1 = 30;
    localparam int SHIFT_2 = 27;
    localparam int SHIFT_3 = 31;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // finalizer phases
    localparam logic [1:0] PH_KEY  = 2'd0;
    localparam logic [1:0] PH_MIX1 = 2'd1;
    localparam logic [1:0] PH_MIX2 = 2'd2;

    // partial product steps
    localparam logic [1:0] ST_LL  = 2'd0;
    localparam logic [1:0] ST_LH  = 2'd1;
    localparam logic [1:0] ST_HL  = 2'd2;
    localparam logic [1:0] ST_SUM = 2'd3;

    typedef struct packed {
        logic [63:0] hash;
        logic [31:0] ordinal;
    } name_entry_t;

    typedef struct packed {
        logic valid;
        logic full;
    } queue_status_t;

    // xor in one byte, multiply by the sparse prime 2^40 + 0x1b3
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8);
    endfunction

endpackage

// ===== hdl/kshash_front.sv =====
// kshash_front: folds name bytes into the running fnv-1a state
// and queues the finished state with its ordinal; uses kshash_pkg
module kshash_front
    import kshash_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_fire,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        last_byte,
    input  logic [31:0] ordinal,
    output logic        push,
    output name_entry_t push_entry
);

    logic [63:0] hash_reg;
    logic [63:0] hash_next;
    logic [63:0] folded;

    always_comb
    begin
        folded = byte_valid ? fnv_step(hash_reg, data_byte) : hash_reg;
        hash_next = hash_reg;
        if (in_fire)
        begin
            hash_next = last_byte ? FNV_BASIS : folded;
        end
    end

    assign push               = in_fire && last_byte;
    assign push_entry.hash    = folded;
    assign push_entry.ordinal = ordinal;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= FNV_BASIS;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

endmodule

// ===== hdl/kshash_fifo.sv =====
// kshash_fifo: short queue of finished name states between front and back
// depth from kshash_pkg
module kshash_fifo
    import kshash_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  name_entry_t   push_entry,
    input  logic          pop,
    output queue_status_t status,
    output name_entry_t   head
);

    name_entry_t        entries [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_PTR_W:0]   count_reg;
    logic [Q_PTR_W:0]   count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

    assign head         = entries[rd_ptr_reg];
    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == (Q_PTR_W + 1)'(Q_DEPTH));

endmodule

// ===== hdl/kshash_back.sv =====
// kshash_back: ordinal keying and splitmix64 finalizer on one shared
// 32x32 multiplier, with a registered output beat; uses kshash_pkg
module kshash_back
    import kshash_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t q_status,
    input  name_entry_t   q_head,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [31:0]   m_data
);

    logic        busy_reg, busy_next;
    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  step_reg, step_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] a_reg, a_next;
    logic [63:0] h_reg, h_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] prod_reg, prod_next;
    logic [31:0] out_data_reg, out_data_next;

    logic [63:0] b_const;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] prod_high;
    logic [63:0] fin;
    logic [63:0] keyed;
    logic [63:0] mixed;
    logic [32:0] ord_plus;
    logic        stall;

    always_comb
    begin
        case (phase_reg)
            PH_KEY:  b_const = GOLDEN;
            PH_MIX1: b_const = MIX_M1;
            default: b_const = MIX_M2;
        endcase
        op_a      = (step_reg == ST_HL) ? a_reg[63:32] : a_reg[31:0];
        op_b      = (step_reg == ST_LH) ? b_const[63:32] : b_const[31:0];
        // last partial product holds while the sum step waits on the output
        prod_next = (step_reg == ST_SUM) ? prod_reg : op_a * op_b;
        prod_high = {prod_reg[31:0], 32'd0};
        fin       = acc_reg + prod_high;
        keyed     = h_reg ^ fin;
        mixed     = fin ^ (fin >> SHIFT_3);
        ord_plus  = {1'b0, q_head.ordinal} + 33'd1;
        stall     = (phase_reg == PH_MIX2) && out_valid_reg && !m_ready;
        pop       = q_status.valid && !busy_reg;
    end

    always_comb
    begin
        busy_next      = busy_reg;
        phase_next     = phase_reg;
        step_next      = step_reg;
        a_next         = a_reg;
        h_next         = h_reg;
        acc_next       = acc_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_ready;

        if (pop)
        begin
            busy_next  = 1'b1;
            phase_next = PH_KEY;
            step_next  = ST_LL;
            a_next     = {31'd0, ord_plus};
            h_next     = q_head.hash;
        end
        else if (busy_reg)
        begin
            case (step_reg)
                ST_LL:
                begin
                    step_next = ST_LH;
                end
                ST_LH:
                begin
                    acc_next  = prod_reg;
                    step_next = ST_HL;
                end
                ST_HL:
                begin
                    acc_next  = fin;
                    step_next = ST_SUM;
                end
                default:
                begin
                    if (!stall)
                    begin
                        step_next = ST_LL;
                        case (phase_reg)
                            PH_KEY:
                            begin
                                a_next     = keyed ^ (keyed >> SHIFT_1);
                                phase_next = PH_MIX1;
                            end
                            PH_MIX1:
                            begin
                                a_next     = fin ^ (fin >> SHIFT_2);
                                phase_next = PH_MIX2;
                            end
                            default:
                            begin
                                out_data_next  = mixed[63:32];
                                out_valid_next = 1'b1;
                                busy_next      = 1'b0;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= PH_KEY;
            step_reg      <= ST_LL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        h_reg        <= h_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== hdl/keyed_string_hash.sv =====
// keyed_string_hash: fnv-1a 64 name hash keyed with an ordinal and finalized
// with the splitmix64 mixer; top level over kshash_front, kshash_fifo, kshash_back
//
// name bytes stream in one per beat and the front end takes a beat every cycle,
// folding the byte in with a shift-add fnv step. a beat with tlast hands the
// folded state and its ordinal to a two-entry queue and restarts the state from
// the offset basis. the back end loads a name, then forms three 64-bit products
// on one 32x32 multiplier in steps ll, lh, hl and sum; it takes the next name
// only once done. names under about 13 bytes are limited by the back end, and
// the input stalls only when the queue is full. one result beat per tlast beat.
module keyed_string_hash
    import kshash_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // data_byte [7:0], ordinal [39:8]
    input  logic        s_axis_tuser,   // byte_valid
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // hash_value [31:0]
);

    logic          in_fire;
    logic          push;
    logic          pop;
    name_entry_t   push_entry;
    name_entry_t   q_head;
    queue_status_t q_status;

    assign s_axis_tready = !q_status.full;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    kshash_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .data_byte  (s_axis_tdata[7:0]),
        .byte_valid (s_axis_tuser),
        .last_byte  (s_axis_tlast),
        .ordinal    (s_axis_tdata[39:8]),
        .push       (push),
        .push_entry (push_entry)
    );

    kshash_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .status     (q_status),
        .head       (q_head)
    );

    kshash_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_head   (q_head),
        .pop      (pop),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_data   (m_axis_tdata)
    );

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_status.full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_status.valid)
        else $error("queue read while empty");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_status.valid) |=> q_status.valid)
        else $error("pushed name missing from queue");
`endif

endmodule
